FILE: design/pffa_pkg.sv
// ----------------------------------------------------------------------------
// pffa_pkg
// Shared sizes, codes and beat types of the page fault frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pffa_pkg;

    localparam int PAGES      = 64;
    localparam int FRAMES     = 16;
    localparam int COUNT_BITS = 16;

    localparam int PAGE_W     = $clog2(PAGES);
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int SCAN_W     = $clog2(PAGES + 1);

    // widths of the register and field encodings
    localparam int NF_W       = 5;
    localparam int NP_W       = 7;
    localparam int RND_W      = 16;
    localparam int TOTAL_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE  = 2'd2;

    localparam logic REQ_FAULT   = 1'b0;
    localparam logic REQ_DIRTY   = 1'b1;
    localparam logic MODE_RANDOM = 1'b0;
    localparam logic MODE_NFU    = 1'b1;

    localparam logic [NF_W-1:0] NF_RESET = NF_W'(FRAMES);
    localparam logic [NP_W-1:0] NP_RESET = NP_W'(PAGES);

    typedef struct packed {
        logic             req_type;
        logic [5:0]       page_index;
        logic [RND_W-1:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         frame_given;
        logic               was_resident;
        logic               rejected;
        logic               evicted_valid;
        logic [5:0]         evicted_page;
        logic               write_back;
        logic [TOTAL_W-1:0] fault_total;
    } t_out_item;

    typedef struct packed {
        logic [FRAME_W-1:0]    frame;
        logic                  dirty;
        logic [COUNT_BITS-1:0] count;
    } t_page_ent;

    localparam int PENT_W = $bits(t_page_ent);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_MOD,
        S_OWN,
        S_SCAN,
        S_EVICT,
        S_FILL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/pffa_ram.sv
// ----------------------------------------------------------------------------
// pffa_ram
// Generic single-write, single-read memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/pffa_rem.sv
// ----------------------------------------------------------------------------
// pffa_rem
// Bit-serial remainder of the random value by the frame count, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pffa_rem
    import pffa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [RND_W-1:0]   i_dividend,
    input  wire logic [NF_W-1:0]    i_divisor,
    output logic                    o_done,
    output logic [FRAME_W-1:0]      o_rem
);

    localparam int STEP_W = $clog2(RND_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RND_W-1:0]  r_shift;
    logic [NF_W-1:0]   r_rem;
    logic [NF_W-1:0]   r_div;
    logic [NF_W-1:0]   n_trial;

    // remainder stays below the divisor, so one subtract per step is enough
    always_comb begin
        n_trial = {r_rem[NF_W-2:0], r_shift[RND_W-1]};
        if (n_trial >= r_div) begin
            n_trial = n_trial - r_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step  <= STEP_W'(RND_W - 1);
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_step  <= r_step - 1'b1;
            r_shift <= {r_shift[RND_W-2:0], 1'b0};
            r_rem   <= n_trial;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[FRAME_W-1:0];

endmodule

`default_nettype wire

FILE: design/page_fault_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_fault_frame_allocator
// Page table and frame pool with random or least-used (NFU) replacement.
// ----------------------------------------------------------------------------
// path: rejects go from S_IDLE to S_DONE and the output register; hits and
//   dirty marks pass S_LOOK first; a miss with a free frame adds S_FILL; a
//   random eviction adds the 16-step remainder unit plus owner and page
//   reads; an NFU eviction adds a scan of the page memory, one entry a cycle.
// throughput: one request at a time, next one taken once the result is in the
//   output register, even while it waits. reset: no memory sweep.
`default_nettype none

module page_fault_frame_allocator
    import pffa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data
);

    // configuration
    logic              r_cfg_mode;
    logic [NF_W-1:0]   r_cfg_frames;
    logic [NP_W-1:0]   r_cfg_pages;

    // control state
    t_state            r_state, n_state;
    logic [TOTAL_W-1:0] r_fault, n_fault;
    logic              r_out_valid, n_out_valid;
    logic [PAGES-1:0]  r_valid, n_valid;
    logic [PAGES-1:0]  r_touched, n_touched;
    logic [FRAMES-1:0] r_busy, n_busy;

    // per-request payload
    logic              r_req, n_req;
    logic [PAGE_W-1:0] r_pg, n_pg;
    logic [RND_W-1:0]  r_rnd, n_rnd;
    logic [NF_W-1:0]   r_nf, n_nf;
    logic              r_mode, n_mode;
    t_out_item         r_res, n_res;
    t_out_item         r_out, n_out;
    logic [FRAME_W-1:0] r_f, n_f;
    logic [PAGE_W-1:0] r_victim, n_victim;
    logic [COUNT_BITS-1:0] r_pg_cnt, n_pg_cnt;
    logic              r_pg_dirty, n_pg_dirty;
    logic              r_rd_touched;

    // nfu scan
    logic [SCAN_W-1:0] r_scan_addr, n_scan_addr;
    logic              r_cmp_live, n_cmp_live;
    logic [PAGE_W-1:0] r_cmp_idx, n_cmp_idx;
    logic              r_have, n_have;
    logic [COUNT_BITS-1:0] r_best, n_best;
    logic [FRAME_W-1:0] r_best_frame, n_best_frame;
    logic [PAGE_W-1:0] r_best_idx, n_best_idx;

    // memory ports
    logic              page_we;
    logic [PAGE_W-1:0] page_waddr;
    t_page_ent         page_wdata;
    logic [PAGE_W-1:0] page_raddr;
    logic [PENT_W-1:0] page_rdata;
    t_page_ent         ent;
    logic              own_we;
    logic [FRAME_W-1:0] own_waddr;
    logic [PAGE_W-1:0] own_wdata;
    logic [FRAME_W-1:0] own_raddr;
    logic [PAGE_W-1:0] own_rdata;

    // remainder unit
    logic              rem_start;
    logic              rem_done;
    logic [FRAME_W-1:0] rem_val;

    // combinational helpers
    logic [NF_W-1:0]   eff_nf;
    logic [NP_W-1:0]   eff_np;
    logic              free_found;
    logic [FRAME_W-1:0] free_frame;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic              cand;

    pffa_ram #(.WIDTH(PENT_W), .DEPTH(PAGES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (page_waddr),
        .i_wdata (page_wdata),
        .i_raddr (page_raddr),
        .o_rdata (page_rdata)
    );

    pffa_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    pffa_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_nf),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    // entries never written read as zero
    assign ent = r_rd_touched ? t_page_ent'(page_rdata) : '0;

    always_comb begin
        if (r_cfg_frames == '0) begin
            eff_nf = NF_W'(1);
        end else if (r_cfg_frames > NF_RESET) begin
            eff_nf = NF_RESET;
        end else begin
            eff_nf = r_cfg_frames;
        end
        if (r_cfg_pages == '0) begin
            eff_np = NP_W'(1);
        end else if (r_cfg_pages > NP_RESET) begin
            eff_np = NP_RESET;
        end else begin
            eff_np = r_cfg_pages;
        end
    end

    // lowest free frame below the frame limit
    always_comb begin
        free_found = 1'b0;
        free_frame = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if ((NF_W+1)'(i) < {1'b0, r_nf} && !r_busy[i]) begin
                free_found = 1'b1;
                free_frame = FRAME_W'(i);
            end
        end
    end

    assign cnt_inc = (ent.count == '1) ? ent.count : ent.count + 1'b1;
    assign cand    = r_valid[r_cmp_idx] && ({1'b0, ent.frame} < r_nf)
                     && (!r_have || ent.count < r_best);

    always_comb begin
        n_state      = r_state;
        n_fault      = r_fault;
        n_out_valid  = r_out_valid;
        n_valid      = r_valid;
        n_touched    = r_touched;
        n_busy       = r_busy;
        n_req        = r_req;
        n_pg         = r_pg;
        n_rnd        = r_rnd;
        n_nf         = r_nf;
        n_mode       = r_mode;
        n_res        = r_res;
        n_out        = r_out;
        n_f          = r_f;
        n_victim     = r_victim;
        n_pg_cnt     = r_pg_cnt;
        n_pg_dirty   = r_pg_dirty;
        n_scan_addr  = r_scan_addr;
        n_cmp_live   = r_cmp_live;
        n_cmp_idx    = r_cmp_idx;
        n_have       = r_have;
        n_best       = r_best;
        n_best_frame = r_best_frame;
        n_best_idx   = r_best_idx;
        page_we      = 1'b0;
        page_waddr   = r_pg;
        page_wdata   = ent;
        page_raddr   = r_pg;
        own_we       = 1'b0;
        own_waddr    = r_f;
        own_wdata    = r_pg;
        own_raddr    = rem_val;
        rem_start    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                page_raddr = i_in_data.page_index;
                if (i_in_valid) begin
                    n_req  = i_in_data.req_type;
                    n_pg   = i_in_data.page_index;
                    n_rnd  = i_in_data.random_value;
                    n_nf   = eff_nf;
                    n_mode = r_cfg_mode;
                    n_res  = '0;
                    n_res.fault_total = r_fault;
                    if ({1'b0, i_in_data.page_index} >= eff_np) begin
                        n_res.rejected = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                page_waddr = r_pg;
                if (r_req == REQ_DIRTY) begin
                    if (r_valid[r_pg]) begin
                        page_we = 1'b1;
                        page_wdata = ent;
                        page_wdata.dirty = 1'b1;
                        n_res.frame_given = ent.frame;
                    end
                    n_state = S_DONE;
                end else begin
                    n_fault = r_fault + 1'b1;
                    n_res.fault_total = r_fault + 1'b1;
                    n_pg_cnt   = cnt_inc;
                    n_pg_dirty = ent.dirty;
                    if (r_valid[r_pg]) begin
                        page_we = 1'b1;
                        page_wdata = ent;
                        page_wdata.count = cnt_inc;
                        n_res.was_resident = 1'b1;
                        n_res.frame_given  = ent.frame;
                        n_state = S_DONE;
                    end else if (free_found) begin
                        n_f = free_frame;
                        n_state = S_FILL;
                    end else if (r_mode == MODE_RANDOM) begin
                        rem_start = 1'b1;
                        n_state = S_MOD;
                    end else begin
                        n_scan_addr = '0;
                        n_cmp_live  = 1'b0;
                        n_have      = 1'b0;
                        n_best_idx  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_MOD: begin
                own_raddr = rem_val;
                if (rem_done) begin
                    n_f = rem_val;
                    n_state = S_OWN;
                end
            end
            S_OWN: begin
                page_raddr = own_rdata;
                n_victim = own_rdata;
                n_state = S_EVICT;
            end
            S_SCAN: begin
                page_raddr = r_scan_addr[PAGE_W-1:0];
                if (r_scan_addr < SCAN_W'(PAGES)) begin
                    n_scan_addr = r_scan_addr + 1'b1;
                    n_cmp_live  = 1'b1;
                    n_cmp_idx   = r_scan_addr[PAGE_W-1:0];
                end else begin
                    n_cmp_live  = 1'b0;
                end
                if (r_cmp_live) begin
                    if (cand) begin
                        n_have       = 1'b1;
                        n_best       = ent.count;
                        n_best_frame = ent.frame;
                        n_best_idx   = r_cmp_idx;
                    end else if (r_cmp_idx == '0) begin
                        // no candidate at all falls back on page zero's frame
                        n_best_frame = ent.frame;
                    end
                end
                if (r_scan_addr == SCAN_W'(PAGES) && !r_cmp_live) begin
                    page_raddr = r_best_idx;
                    n_victim = r_best_idx;
                    n_f = r_best_frame;
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                page_we = 1'b1;
                page_waddr = r_victim;
                page_wdata = '0;
                if (r_mode == MODE_RANDOM) begin
                    page_wdata.count = ent.count;
                end
                n_valid[r_victim] = 1'b0;
                n_res.evicted_valid = 1'b1;
                n_res.evicted_page  = r_victim;
                n_res.write_back    = ent.dirty;
                n_state = S_FILL;
            end
            S_FILL: begin
                page_we = 1'b1;
                page_waddr = r_pg;
                page_wdata.frame = r_f;
                page_wdata.dirty = r_pg_dirty;
                page_wdata.count = r_pg_cnt;
                own_we = 1'b1;
                own_waddr = r_f;
                own_wdata = r_pg;
                n_busy[r_f] = 1'b1;
                n_valid[r_pg] = 1'b1;
                n_res.frame_given = r_f;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out = r_res;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (page_we) begin
            n_touched[page_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fault      <= '0;
            r_out_valid  <= 1'b0;
            r_valid      <= '0;
            r_touched    <= '0;
            r_busy       <= '0;
            r_cfg_mode   <= MODE_NFU;
            r_cfg_frames <= NF_RESET;
            r_cfg_pages  <= NP_RESET;
        end else begin
            r_state     <= n_state;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
            r_valid     <= n_valid;
            r_touched   <= n_touched;
            r_busy      <= n_busy;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REPLACE_MODE:  r_cfg_mode   <= i_cfg_data[0];
                    CFG_FRAMES_IN_USE: r_cfg_frames <= i_cfg_data[NF_W-1:0];
                    CFG_PAGES_IN_USE:  r_cfg_pages  <= i_cfg_data[NP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_pg         <= n_pg;
        r_rnd        <= n_rnd;
        r_nf         <= n_nf;
        r_mode       <= n_mode;
        r_res        <= n_res;
        r_out        <= n_out;
        r_f          <= n_f;
        r_victim     <= n_victim;
        r_pg_cnt     <= n_pg_cnt;
        r_pg_dirty   <= n_pg_dirty;
        r_scan_addr  <= n_scan_addr;
        r_cmp_live   <= n_cmp_live;
        r_cmp_idx    <= n_cmp_idx;
        r_have       <= n_have;
        r_best       <= n_best;
        r_best_frame <= n_best_frame;
        r_best_idx   <= n_best_idx;
        r_rd_touched <= r_touched[page_raddr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
